// ===== rtl/core/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants of the Markov sequence sampler.
// ----------------------------------------------------------------------------
package mss_pkg;

	localparam int STATE_W   = 6;   // holds any state, start or end state index
	localparam int COUNT_W   = 16;
	localparam int CMD_W     = 2;
	localparam int IDX_IN_W  = 4;
	localparam int PROB_IN_W = 16;
	localparam int SYM_OUT_W = 4;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_WR_TRANS = 2'd0,
		CMD_WR_EMIT  = 2'd1,
		CMD_START    = 2'd2,
		CMD_STEP     = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		REG_RUN_MODE    = 2'd0,
		REG_FIRST_STATE = 2'd1,
		REG_KMER_LENGTH = 2'd2,
		REG_MIN_LENGTH  = 2'd3
	} reg_idx_e;

	typedef enum logic [1:0] {
		FSM_IDLE   = 2'd0,
		FSM_SCAN1  = 2'd1,
		FSM_SCAN2  = 2'd2,
		FSM_FINISH = 2'd3
	} fsm_e;

	typedef enum logic {
		TBL_TRANS = 1'b0,
		TBL_EMIT  = 1'b1
	} tbl_e;

	typedef struct packed {
		logic accept;
		logic scan_run;
		tbl_e scan_tbl;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic running;
		logic scan_end;
		logic out_free;
	} dp_status_t;

	typedef struct packed {
		logic               run_mode;
		logic [IDX_IN_W-1:0] first_state;
		logic [COUNT_W-1:0]  kmer_length;
		logic [COUNT_W-1:0]  min_length;
	} cfg_t;

endpackage

// ===== rtl/core/mss_ram.sv =====
// ----------------------------------------------------------------------------
// mss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/mss_ctrl.sv =====
// ----------------------------------------------------------------------------
// mss_ctrl
// Sequencer: accept, then for a step of a live run a first and a second table search, then result.
// ----------------------------------------------------------------------------
module mss_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [mss_pkg::CMD_W-1:0] command,
	input  logic                     run_mode,
	input  mss_pkg::dp_status_t      status,
	output mss_pkg::ctrl_cmd_t       cmd,
	output logic                     in_stall
);
	import mss_pkg::*;

	fsm_e fsm_q, fsm_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= FSM_IDLE;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			FSM_IDLE: begin
				if (in_valid) begin
					// only a step of a live run needs the table searches
					if (cmd_e'(command) == CMD_STEP && status.running) begin
						fsm_d = FSM_SCAN1;
					end else begin
						fsm_d = FSM_FINISH;
					end
				end
			end
			FSM_SCAN1: begin
				if (status.scan_end) fsm_d = FSM_SCAN2;
			end
			FSM_SCAN2: begin
				if (status.scan_end) fsm_d = FSM_FINISH;
			end
			FSM_FINISH: begin
				if (status.out_free) fsm_d = FSM_IDLE;
			end
			default: fsm_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (fsm_q != FSM_IDLE);
		cmd.accept   = (fsm_q == FSM_IDLE) && in_valid;
		cmd.scan_run = (fsm_q == FSM_SCAN1) || (fsm_q == FSM_SCAN2);
		cmd.finish   = (fsm_q == FSM_FINISH);
		// sequence mode: transition then emission; k-mer mode the other way
		if (fsm_q == FSM_SCAN1) begin
			cmd.scan_tbl = run_mode ? TBL_EMIT : TBL_TRANS;
		end else begin
			cmd.scan_tbl = run_mode ? TBL_TRANS : TBL_EMIT;
		end
	end

endmodule

// ===== rtl/core/mss_datapath.sv =====
// ----------------------------------------------------------------------------
// mss_datapath
// Table RAMs, inverse cumulative search, run state and result register.
// ----------------------------------------------------------------------------
module mss_datapath #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 4,
	parameter int PROB_BITS   = 16,
	parameter int BEGIN_STATE = 0,
	parameter int FINAL_STATE = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mss_pkg::ctrl_cmd_t           cmd,
	output mss_pkg::dp_status_t          status,
	input  mss_pkg::cfg_t                cfg,
	input  logic [mss_pkg::CMD_W-1:0]     command,
	input  logic [mss_pkg::IDX_IN_W-1:0]  row,
	input  logic [mss_pkg::IDX_IN_W-1:0]  column,
	input  logic [mss_pkg::PROB_IN_W-1:0] prob_value,
	input  logic [mss_pkg::PROB_IN_W-1:0] rand_transition,
	input  logic [mss_pkg::PROB_IN_W-1:0] rand_emission,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mss_pkg::SYM_OUT_W-1:0] symbol,
	output logic                         symbol_valid,
	output logic                         run_done,
	output logic [mss_pkg::COUNT_W-1:0]   run_length,
	output logic [mss_pkg::SYM_OUT_W-1:0] current_state
);
	import mss_pkg::*;

	localparam int SIW    = $clog2(NUM_STATES);
	localparam int YW     = $clog2(NUM_SYMBOLS);
	localparam int NMAX   = (NUM_STATES > NUM_SYMBOLS) ? NUM_STATES : NUM_SYMBOLS;
	localparam int IXW    = $clog2(NMAX + 1);
	localparam int TDEPTH = 1 << (2 * SIW);
	localparam int EDEPTH = 1 << (SIW + YW);

	// run state
	logic [STATE_W-1:0]   state_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 running_q;
	// item and per-step results
	cmd_e                 cmd_q;
	logic [PROB_BITS-1:0] rt_q, re_q;
	logic [YW-1:0]        sym_q;
	logic                 symv_q;
	// search
	logic [IXW-1:0]       ix_q, cmp_ix_s1;
	logic                 cmp_vld_s1;
	// result register
	logic                 out_valid_q;
	logic [SYM_OUT_W-1:0] sym_out_q, state_out_q;
	logic                 symv_out_q, done_out_q;
	logic [COUNT_W-1:0]   len_out_q;

	// ---- table writes, straight from the accepted beat ----
	logic [STATE_W-1:0]       row_x, col_x;
	logic                     row_ok, t_col_ok, e_col_ok;
	logic                     t_we, e_we;
	logic [PROB_BITS-1:0]     wdata;
	logic [2*SIW-1:0]         t_waddr, t_raddr;
	logic [SIW+YW-1:0]        e_waddr, e_raddr;
	logic [PROB_BITS-1:0]     t_rdata, e_rdata;

	assign row_x    = STATE_W'(row);
	assign col_x    = STATE_W'(column);
	assign row_ok   = 32'(row) < 32'(NUM_STATES);
	assign t_col_ok = 32'(column) < 32'(NUM_STATES);
	assign e_col_ok = 32'(column) < 32'(NUM_SYMBOLS);
	assign t_we     = cmd.accept && (cmd_e'(command) == CMD_WR_TRANS) && row_ok && t_col_ok;
	assign e_we     = cmd.accept && (cmd_e'(command) == CMD_WR_EMIT) && row_ok && e_col_ok;
	assign wdata    = PROB_BITS'(prob_value);
	assign t_waddr  = {row_x[SIW-1:0], col_x[SIW-1:0]};
	assign e_waddr  = {row_x[SIW-1:0], col_x[YW-1:0]};
	assign t_raddr  = {state_q[SIW-1:0], ix_q[SIW-1:0]};
	assign e_raddr  = {state_q[SIW-1:0], ix_q[YW-1:0]};

	mss_ram #(.WIDTH(PROB_BITS), .DEPTH(TDEPTH)) u_trans_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	mss_ram #(.WIDTH(PROB_BITS), .DEPTH(EDEPTH)) u_emit_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	// ---- search: issue one column a cycle, compare it in the cycle after ----
	logic                 st_ok;
	logic [PROB_BITS-1:0] v_raw, v_eff, r_sel;
	logic [IXW-1:0]       lim, lim_m1;
	logic                 issue, hit, last, scan_end;

	assign st_ok  = 32'(state_q) < 32'(NUM_STATES);
	assign v_raw  = (cmd.scan_tbl == TBL_TRANS) ? t_rdata : e_rdata;
	assign v_eff  = st_ok ? v_raw : '0;  // rows beyond the model read as zero
	assign r_sel  = (cmd.scan_tbl == TBL_TRANS) ? rt_q : re_q;
	assign lim    = (cmd.scan_tbl == TBL_TRANS) ? IXW'(NUM_STATES) : IXW'(NUM_SYMBOLS);
	assign lim_m1 = lim - IXW'(1);
	assign issue  = cmd.scan_run && (ix_q < lim);
	assign hit    = cmp_vld_s1 && (r_sel <= v_eff);
	assign last   = cmp_vld_s1 && (cmp_ix_s1 == lim_m1);
	assign scan_end = cmd.scan_run && (hit || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ix_q       <= '0;
			cmp_vld_s1 <= 1'b0;
		end else if (!cmd.scan_run || scan_end) begin
			ix_q       <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (issue) ix_q <= ix_q + IXW'(1);
		end
	end

	always_ff @(posedge clk) begin
		cmp_ix_s1 <= ix_q;
	end

	// ---- end of command: start, run end and restart rules ----
	logic                 out_free, load;
	logic [STATE_W-1:0]   fin_state;
	logic [COUNT_W-1:0]   fin_count;
	logic                 fin_running, fin_done;

	assign out_free = !out_valid_q || !out_stall;
	assign load     = cmd.finish && out_free;

	always_comb begin
		fin_state   = state_q;
		fin_count   = count_q;
		fin_running = running_q;
		fin_done    = 1'b0;
		unique case (cmd_q)
			CMD_START: begin
				fin_count   = '0;
				fin_running = 1'b1;
				if (!cfg.run_mode) begin
					fin_state = STATE_W'(BEGIN_STATE);
				end else begin
					fin_state = STATE_W'(cfg.first_state);
					if (fin_state == STATE_W'(FINAL_STATE) || cfg.kmer_length == '0) begin
						fin_running = 1'b0;
						fin_done    = 1'b1;
					end
				end
			end
			CMD_STEP: begin
				if (running_q) begin
					if (!cfg.run_mode) begin
						if (state_q == STATE_W'(FINAL_STATE)) begin
							if (count_q >= cfg.min_length) begin
								fin_running = 1'b0;
								fin_done    = 1'b1;
							end else begin
								fin_state = STATE_W'(BEGIN_STATE);
							end
						end
					end else if (state_q == STATE_W'(FINAL_STATE) ||
					             count_q == cfg.kmer_length) begin
						fin_running = 1'b0;
						fin_done    = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			count_q   <= '0;
			running_q <= 1'b0;
		end else if (scan_end) begin
			if (hit) begin
				if (cmd.scan_tbl == TBL_TRANS) begin
					state_q <= STATE_W'(cmp_ix_s1);
				end else if (count_q != '1) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end
		end else if (load) begin
			state_q   <= fin_state;
			count_q   <= fin_count;
			running_q <= fin_running;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q  <= cmd_e'(command);
			rt_q   <= PROB_BITS'(rand_transition);
			re_q   <= PROB_BITS'(rand_emission);
			sym_q  <= '0;
			symv_q <= 1'b0;
		end else if (scan_end && hit && cmd.scan_tbl == TBL_EMIT) begin
			sym_q  <= cmp_ix_s1[YW-1:0];
			symv_q <= 1'b1;
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sym_out_q   <= SYM_OUT_W'(sym_q);
			symv_out_q  <= symv_q;
			done_out_q  <= fin_done;
			len_out_q   <= fin_count;
			state_out_q <= fin_state[SYM_OUT_W-1:0];
		end
	end

	assign status.running  = running_q;
	assign status.scan_end = scan_end;
	assign status.out_free = out_free;

	assign out_valid     = out_valid_q;
	assign symbol        = sym_out_q;
	assign symbol_valid  = symv_out_q;
	assign run_done      = done_out_q;
	assign run_length    = len_out_q;
	assign current_state = state_out_q;

endmodule

// ===== rtl/core/markov_sequence_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// markov_sequence_sampler_unit
// Hidden Markov model sequence sampler with APB configuration registers.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result beat. Table writes,
// start commands and steps outside a run go from accept straight to the
// result state. A step of a live run searches two cumulative rows, one entry
// per cycle from registered-read table RAMs; a search stops at the first
// entry not below its random value or at the row's last entry. A held result
// beat keeps the next command in the result state until the beat is taken.
// Tables are undefined after reset and must be written before use.
module markov_sequence_sampler_unit #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 4,
	parameter int PROB_BITS   = 16,
	parameter int BEGIN_STATE = 0,
	parameter int FINAL_STATE = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mss_pkg::APB_AW-1:0]    paddr,
	input  logic [mss_pkg::APB_DW-1:0]    pwdata,
	output logic [mss_pkg::APB_DW-1:0]    prdata,
	output logic                         pready,
	// command channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mss_pkg::CMD_W-1:0]     command,
	input  logic [mss_pkg::IDX_IN_W-1:0]  row,
	input  logic [mss_pkg::IDX_IN_W-1:0]  column,
	input  logic [mss_pkg::PROB_IN_W-1:0] prob_value,
	input  logic [mss_pkg::PROB_IN_W-1:0] rand_transition,
	input  logic [mss_pkg::PROB_IN_W-1:0] rand_emission,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mss_pkg::SYM_OUT_W-1:0] symbol,
	output logic                         symbol_valid,
	output logic                         run_done,
	output logic [mss_pkg::COUNT_W-1:0]   run_length,
	output logic [mss_pkg::SYM_OUT_W-1:0] current_state
);
	import mss_pkg::*;

	cfg_t       cfg_q;
	reg_idx_e   reg_idx;
	logic       wr_en;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_e'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_mode    <= 1'b0;
			cfg_q.first_state <= '0;
			cfg_q.kmer_length <= COUNT_W'(16);
			cfg_q.min_length  <= COUNT_W'(16);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RUN_MODE:    cfg_q.run_mode    <= pwdata[0];
				REG_FIRST_STATE: cfg_q.first_state <= pwdata[IDX_IN_W-1:0];
				REG_KMER_LENGTH: cfg_q.kmer_length <= pwdata[COUNT_W-1:0];
				REG_MIN_LENGTH:  cfg_q.min_length  <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RUN_MODE:    prdata = APB_DW'(cfg_q.run_mode);
			REG_FIRST_STATE: prdata = APB_DW'(cfg_q.first_state);
			REG_KMER_LENGTH: prdata = APB_DW'(cfg_q.kmer_length);
			REG_MIN_LENGTH:  prdata = APB_DW'(cfg_q.min_length);
			default:         prdata = '0;
		endcase
	end

	mss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.run_mode (cfg_q.run_mode),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	mss_datapath #(
		.NUM_STATES  (NUM_STATES),
		.NUM_SYMBOLS (NUM_SYMBOLS),
		.PROB_BITS   (PROB_BITS),
		.BEGIN_STATE (BEGIN_STATE),
		.FINAL_STATE (FINAL_STATE)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg             (cfg_q),
		.command         (command),
		.row             (row),
		.column          (column),
		.prob_value      (prob_value),
		.rand_transition (rand_transition),
		.rand_emission   (rand_emission),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.symbol          (symbol),
		.symbol_valid    (symbol_valid),
		.run_done        (run_done),
		.run_length      (run_length),
		.current_state   (current_state)
	);

endmodule
